### hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion helpers used by the min priority queue RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`else
`define ASSERT_ALWAYS(label, clk, rst_n, cond, msg)
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg)
`endif
`endif

### hw/rtl/mpq_pkg.sv
// ----------------------------------------------------------------------------
// Min priority queue package
// Widths and constants used by the queue and to size its key memory.
// ----------------------------------------------------------------------------
package mpq_pkg;
    localparam int KEY_W   = 32;
    localparam int COUNT_W = 7;

    localparam logic signed [KEY_W-1:0] INT_MAX = 32'sh7FFF_FFFF;

    typedef logic signed [KEY_W-1:0] t_key;

    typedef enum logic {
        CMD_INSERT = 1'b0,
        CMD_DELETE = 1'b1
    } t_cmd;
endpackage

### hw/rtl/mpq_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module mpq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

### hw/rtl/min_priority_queue.sv
// ----------------------------------------------------------------------------
// Min priority queue
// Bounded min-priority queue of signed keys held as a binary heap in RAM.
// ----------------------------------------------------------------------------
// The keys live in a binary heap in one RAM with a single read and a single
// write port. An insert sifts the new key up, reading the parent and then
// comparing and writing at each tree level; a delete moves the last key to
// the root and sifts it down, reading the left child, then the right child,
// then comparing and writing at each level. A result is held until i_ready
// takes it, and the queue takes one item at a time. Every item gives one
// result with the minimum after the operation (2147483647 when empty), the
// count and the flags.
`include "assert_macros.svh"

module min_priority_queue #(
    parameter int CAPACITY = 64
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic                        i_cmd,
    input  logic signed [31:0]          i_key,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic signed [31:0]          o_min_key,
    output logic [6:0]                  o_count,
    output logic                        o_empty_res,
    output logic                        o_full_res,
    output logic                        o_rejected
);
    import mpq_pkg::*;

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int PW = CW + 1;
    localparam logic [CW-1:0] CAP = CW'(CAPACITY);

    typedef enum logic [2:0] {
        S_IDLE, S_INS_CHK, S_INS_CMP, S_DEL_LAST, S_DEL_CHK, S_DEL_L, S_DEL_R, S_DONE
    } t_state;

    t_state        r_state, n_state;
    logic [CW-1:0] r_count, n_count;
    logic [CW-1:0] r_pos, n_pos;
    logic [CW-1:0] r_par, n_par;
    logic [CW-1:0] r_cpos, n_cpos;
    t_key          r_key, n_key;
    t_key          r_lv, n_lv;
    t_key          r_cv, n_cv;
    t_key          r_root, n_root;
    logic          r_rej, n_rej;
    logic          r_o_valid, n_o_valid;
    t_key          r_o_min, n_o_min;
    logic [CW-1:0] r_o_count, n_o_count;
    logic          r_o_rej, n_o_rej;

    logic          w_we;
    logic [AW-1:0] w_waddr, w_raddr;
    t_key          w_wdata;
    logic [KEY_W-1:0] w_rdata;
    t_key          w_rd;
    logic [PW-1:0] w_left;

    mpq_ram #(.WIDTH(KEY_W), .DEPTH(CAPACITY)) u_ram (
        .i_clk  (i_clk),
        .i_we   (w_we),
        .i_waddr(w_waddr),
        .i_wdata(w_wdata),
        .i_raddr(w_raddr),
        .o_rdata(w_rdata)
    );

    assign w_rd   = $signed(w_rdata);
    assign w_left = {r_pos, 1'b1};
    assign o_ready = (r_state == S_IDLE);

    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_pos     = r_pos;
        n_par     = r_par;
        n_cpos    = r_cpos;
        n_key     = r_key;
        n_lv      = r_lv;
        n_cv      = r_cv;
        n_root    = r_root;
        n_rej     = r_rej;
        n_o_valid = r_o_valid;
        n_o_min   = r_o_min;
        n_o_count = r_o_count;
        n_o_rej   = r_o_rej;
        w_we      = 1'b0;
        w_waddr   = AW'(r_pos);
        w_wdata   = r_key;
        w_raddr   = '0;

        if (r_o_valid && i_ready) begin
            n_o_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_key = i_key;
                    n_rej = 1'b0;
                    if (t_cmd'(i_cmd) == CMD_INSERT) begin
                        if (r_count == CAP) begin
                            n_rej   = 1'b1;
                            n_state = S_DONE;
                        end else begin
                            n_pos   = r_count;
                            n_count = r_count + 1'b1;
                            n_state = S_INS_CHK;
                        end
                    end else begin
                        if (r_count == '0) begin
                            n_rej   = 1'b1;
                            n_state = S_DONE;
                        end else begin
                            n_count = r_count - 1'b1;
                            w_raddr = AW'(r_count - 1'b1);
                            n_state = (r_count == CW'(1)) ? S_DONE : S_DEL_LAST;
                        end
                    end
                end
            end
            S_INS_CHK: begin
                if (r_pos == '0) begin
                    w_we    = 1'b1;
                    n_root  = r_key;
                    n_state = S_DONE;
                end else begin
                    n_par   = (r_pos - 1'b1) >> 1;
                    w_raddr = AW'((r_pos - 1'b1) >> 1);
                    n_state = S_INS_CMP;
                end
            end
            S_INS_CMP: begin
                w_we = 1'b1;
                if (r_key < w_rd) begin
                    w_wdata = w_rd;
                    if (r_pos == '0) begin
                        n_root = w_rd;
                    end
                    n_pos   = r_par;
                    n_state = S_INS_CHK;
                end else begin
                    if (r_pos == '0) begin
                        n_root = r_key;
                    end
                    n_state = S_DONE;
                end
            end
            S_DEL_LAST: begin
                n_key   = w_rd;
                n_pos   = '0;
                n_state = S_DEL_CHK;
            end
            S_DEL_CHK: begin
                if (w_left >= PW'(r_count)) begin
                    w_we = 1'b1;
                    if (r_pos == '0) begin
                        n_root = r_key;
                    end
                    n_state = S_DONE;
                end else begin
                    w_raddr = AW'(w_left);
                    n_state = S_DEL_L;
                end
            end
            S_DEL_L: begin
                n_lv = w_rd;
                if (w_left + 1'b1 < PW'(r_count)) begin
                    w_raddr = AW'(w_left + 1'b1);
                    n_state = S_DEL_R;
                end else begin
                    n_cv    = w_rd;
                    n_cpos  = CW'(w_left);
                    n_state = S_DEL_R;
                end
            end
            S_DEL_R: begin
                if (w_left + 1'b1 < PW'(r_count) && w_rd < r_lv) begin
                    n_cv   = w_rd;
                    n_cpos = CW'(w_left + 1'b1);
                end else if (w_left + 1'b1 < PW'(r_count)) begin
                    n_cv   = r_lv;
                    n_cpos = CW'(w_left);
                end
                n_state = S_DEL_CHK;
                w_we    = 1'b1;
                if (n_cv < r_key) begin
                    w_wdata = n_cv;
                    if (r_pos == '0) begin
                        n_root = n_cv;
                    end
                    n_pos = n_cpos;
                end else begin
                    if (r_pos == '0) begin
                        n_root = r_key;
                    end
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (!r_o_valid || i_ready) begin
                    n_o_valid = 1'b1;
                    n_o_min   = (r_count == '0) ? INT_MAX : r_root;
                    n_o_count = r_count;
                    n_o_rej   = r_rej;
                    n_state   = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_count   <= '0;
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_o_valid <= n_o_valid;
        end
        r_pos     <= n_pos;
        r_par     <= n_par;
        r_cpos    <= n_cpos;
        r_key     <= n_key;
        r_lv      <= n_lv;
        r_cv      <= n_cv;
        r_root    <= n_root;
        r_rej     <= n_rej;
        r_o_min   <= n_o_min;
        r_o_count <= n_o_count;
        r_o_rej   <= n_o_rej;
    end

    assign o_valid     = r_o_valid;
    assign o_min_key   = r_o_min;
    assign o_count     = COUNT_W'(r_o_count);
    assign o_empty_res = (r_o_count == '0);
    assign o_full_res  = (r_o_count == CAP);
    assign o_rejected  = r_o_rej;

    `ASSERT_ALWAYS(a_count_bound, i_clk, i_rst_n, r_count <= CAP, "count above capacity")
    `ASSERT_IMPLY(a_count_step, i_clk, i_rst_n, r_state != S_IDLE,
        r_count == $past(r_count) || $past(r_state) == S_IDLE, "count changed mid operation")
    `ASSERT_IMPLY(a_empty_min, i_clk, i_rst_n, o_valid && o_empty_res,
        o_min_key == INT_MAX, "empty queue reports a key")
    `ASSERT_IMPLY(a_sift_write, i_clk, i_rst_n, w_we,
        r_state != S_IDLE && r_state != S_DONE, "heap write outside an operation")
endmodule
